FILE: sv/sfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and byte-class helpers for the stream find/replace core.
// Used by every module of the block; depends on nothing.
package sfr_pkg;

  // Sizes of the search and replace strings
  localparam int unsigned NEEDLE_MAX     = 8;
  localparam int unsigned REPLACE_MAX    = 8;
  localparam int unsigned LINE_MAX       = 4096;
  localparam int unsigned LINE_COUNT_CAP = (LINE_MAX < 8191) ? LINE_MAX : 8191;

  localparam int unsigned WIN_DEPTH  = 8;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned STR_W      = 64;
  localparam int unsigned LINE_CNT_W = 13;
  localparam int unsigned COUNT_W    = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] UNDERSCORE = 8'h5F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEEDLE_BYTES  = 3'd0,
    REG_NEEDLE_LEN    = 3'd1,
    REG_REPL_BYTES    = 3'd2,
    REG_REPL_LEN      = 3'd3,
    REG_MATCH_CASE    = 3'd4,
    REG_WHOLE_WORD    = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_EOL  = 2'd1,
    FUNC_EOB  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_EOB  = 2'd2
  } kind_e;

  // One job: up to eight bytes, then an optional report
  typedef struct packed {
    logic [STR_W-1:0]   data;
    logic [LEN_W-1:0]   nbytes;
    logic               rep_en;
    kind_e              rep_kind;
    logic [COUNT_W-1:0] count;
  } job_t;

  // Letters, digits and underscore
  function automatic logic is_word(input logic [7:0] c);
    is_word = ((c >= 8'h30) && (c <= 8'h39)) ||
              ((c >= 8'h61) && (c <= 8'h7A)) ||
              ((c >= 8'h41) && (c <= 8'h5A)) ||
              (c == UNDERSCORE);
  endfunction

  // Map upper-case ASCII letters to lower case
  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'h20) : c;
  endfunction

endpackage

FILE: sv/sfr_job_fifo.sv
`timescale 1ns / 1ps
// Small job queue between the front and back ends.
// Depends on sfr_pkg for the job type and the queue depth.
module sfr_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sfr_pkg::job_t head_o
);
  import sfr_pkg::*;

  job_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Track occupancy
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/sfr_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, match window, match decision and line counters.
// Turns each accepted item into at most one job. Depends on sfr_pkg.
module sfr_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       func_i,
  input  logic [7:0]                       in_byte_i,
  input  logic                             cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             queue_full_i,
  output logic                             job_push_o,
  output sfr_pkg::job_t                    job_o
);
  import sfr_pkg::*;

  // Configuration
  logic [STR_W-1:0] needle_q, repl_q;
  logic [LEN_W-1:0] needle_len_q, repl_len_q;
  logic             match_case_q, word_only_q;

  // Line state
  logic [7:0]            window_q [WIN_DEPTH];
  logic [7:0]            window_d [WIN_DEPTH];
  logic [LEN_W-1:0]      fill_q, fill_d;
  logic [7:0]            left_byte_q, left_byte_d;
  logic                  left_valid_q, left_valid_d;
  logic [LINE_CNT_W-1:0] line_cnt_q, line_cnt_d;
  logic [COUNT_W-1:0]    total_q, total_d;

  logic                  accept;
  logic [LEN_W-1:0]      len_eff, repl_eff, fill_m1, repl_m1;
  logic                  all_eq, left_ok, core_hit, cand, eol_hit;
  logic [STR_W-1:0]      window_packed, repl_shift;
  logic [COUNT_W:0]      total_sum;
  logic [LINE_CNT_W-1:0] line_inc, eol_cnt;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Clamp lengths
  assign len_eff  = (needle_len_q > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX) : needle_len_q;
  assign repl_eff = (repl_len_q > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : repl_len_q;
  assign fill_m1  = fill_q - 1'b1;
  assign repl_m1  = repl_eff - 1'b1;
  assign repl_shift = repl_q >> {repl_m1[2:0], 3'b000};

  // Compare window against needle, byte lanes in parallel
  always_comb begin
    logic [7:0] nb;
    logic       hit;
    all_eq = 1'b1;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      nb  = needle_q[k*8 +: 8];
      hit = match_case_q ? (window_q[k] == nb) : (fold(window_q[k]) == fold(nb));
      all_eq = all_eq && (hit || (LEN_W'(k) >= len_eff));
      window_packed[k*8 +: 8] = window_q[k];
    end
  end

  assign left_ok  = !left_valid_q || !is_word(left_byte_q);
  assign core_hit = all_eq && (!word_only_q || left_ok);
  assign cand     = (len_eff != '0) && (fill_q == len_eff);

  assign line_inc  = (line_cnt_q < LINE_CNT_W'(LINE_COUNT_CAP)) ? line_cnt_q + 1'b1
                                                                 : line_cnt_q;
  // A match at line end counts before the line is reported
  assign eol_hit   = cand && core_hit;
  assign eol_cnt   = eol_hit ? line_inc : line_cnt_q;
  assign total_sum = {1'b0, total_q} + (COUNT_W + 1)'(eol_cnt);

  // Decide the action for the accepted item
  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) window_d[k] = window_q[k];
    fill_d       = fill_q;
    left_byte_d  = left_byte_q;
    left_valid_d = left_valid_q;
    line_cnt_d   = line_cnt_q;
    total_d      = total_q;
    job_push_o   = 1'b0;
    job_o        = '0;
    job_o.rep_kind = KIND_BYTE;
    if (accept) begin
      case (func_i)
        FUNC_BYTE: begin
          if (fill_q < len_eff) begin
            // Fill the window
            window_d[fill_q[2:0]] = in_byte_i;
            fill_d = fill_q + 1'b1;
          end else if (cand && core_hit && (!word_only_q || !is_word(in_byte_i))) begin
            // Replace the match and restart the window
            job_o.data   = repl_q;
            job_o.nbytes = repl_eff;
            job_push_o   = (repl_eff != '0);
            if (repl_eff != '0) begin
              left_byte_d  = repl_shift[7:0];
              left_valid_d = 1'b1;
            end
            line_cnt_d  = line_inc;
            window_d[0] = in_byte_i;
            fill_d      = LEN_W'(1);
          end else if (fill_q == '0) begin
            // Pass the byte straight through
            job_o.data   = STR_W'(in_byte_i);
            job_o.nbytes = LEN_W'(1);
            job_push_o   = 1'b1;
            left_byte_d  = in_byte_i;
            left_valid_d = 1'b1;
          end else begin
            // Emit the oldest byte and shift the window
            job_o.data   = STR_W'(window_q[0]);
            job_o.nbytes = LEN_W'(1);
            job_push_o   = 1'b1;
            left_byte_d  = window_q[0];
            left_valid_d = 1'b1;
            for (int k = 0; k < WIN_DEPTH - 1; k++) window_d[k] = window_q[k+1];
            window_d[fill_m1[2:0]] = in_byte_i;
          end
        end
        FUNC_EOL: begin
          // Flush or replace the window, then report the line count
          if (eol_hit) begin
            job_o.data   = repl_q;
            job_o.nbytes = repl_eff;
          end else begin
            job_o.data   = window_packed;
            job_o.nbytes = fill_q;
          end
          job_o.rep_en   = 1'b1;
          job_o.rep_kind = KIND_EOL;
          job_o.count    = COUNT_W'(eol_cnt);
          job_push_o     = 1'b1;
          fill_d         = '0;
          total_d        = total_sum[COUNT_W] ? '1 : total_sum[COUNT_W-1:0];
          line_cnt_d     = '0;
          left_valid_d   = 1'b0;
          left_byte_d    = '0;
        end
        FUNC_EOB: begin
          // Report and clear the buffer total
          job_o.rep_en   = 1'b1;
          job_o.rep_kind = KIND_EOB;
          job_o.count    = total_q;
          job_push_o     = 1'b1;
          total_d        = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q     <= '0;
      needle_len_q <= '0;
      repl_q       <= '0;
      repl_len_q   <= '0;
      match_case_q <= 1'b1;
      word_only_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NEEDLE_BYTES: needle_q     <= cfg_data_i;
        REG_NEEDLE_LEN:   needle_len_q <= cfg_data_i[LEN_W-1:0];
        REG_REPL_BYTES:   repl_q       <= cfg_data_i;
        REG_REPL_LEN:     repl_len_q   <= cfg_data_i[LEN_W-1:0];
        REG_MATCH_CASE:   match_case_q <= cfg_data_i[0];
        REG_WHOLE_WORD:   word_only_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Line and buffer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      left_byte_q  <= '0;
      left_valid_q <= 1'b0;
      line_cnt_q   <= '0;
      total_q      <= '0;
    end else begin
      fill_q       <= fill_d;
      left_byte_q  <= left_byte_d;
      left_valid_q <= left_valid_d;
      line_cnt_q   <= line_cnt_d;
      total_q      <= total_d;
    end
  end

  // Window bytes
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < WIN_DEPTH; k++) window_q[k] <= window_d[k];
  end

endmodule

FILE: sv/sfr_back.sv
`timescale 1ns / 1ps
// Back end: expands the job at the head of the queue into result items.
// Drives the registered output channel. Depends on sfr_pkg.
module sfr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  sfr_pkg::job_t                 job_i,
  output logic                          job_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    out_kind_o,
  output logic [7:0]                    out_byte_o,
  output logic [sfr_pkg::COUNT_W-1:0]   match_count_o,
  output logic                          last_of_run_o
);
  import sfr_pkg::*;

  logic [LEN_W-1:0]   pos_q, total;
  logic               out_valid_q, emit, is_byte, is_last;
  kind_e              kind_q;
  logic [7:0]         byte_q;
  logic [COUNT_W-1:0] count_q;
  logic               last_q;
  logic [STR_W-1:0]   data_shift;

  assign total      = job_i.nbytes + LEN_W'(job_i.rep_en);
  assign is_last    = (pos_q == total - 1'b1);
  assign is_byte    = (pos_q < job_i.nbytes);
  assign data_shift = job_i.data >> {pos_q[2:0], 3'b000};

  // Load the output register when it is free or being drained
  assign emit      = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_pop_o = emit && is_last;

  // Position within the job and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        pos_q <= is_last ? '0 : pos_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (is_byte) begin
        kind_q  <= KIND_BYTE;
        byte_q  <= data_shift[7:0];
        count_q <= '0;
      end else begin
        kind_q  <= job_i.rep_kind;
        byte_q  <= '0;
        count_q <= job_i.count;
      end
      last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = kind_q;
  assign out_byte_o    = byte_q;
  assign match_count_o = count_q;
  assign last_of_run_o = last_q;

endmodule

FILE: sv/stream_find_replace_core.sv
`timescale 1ns / 1ps
// Top level of the streaming find/replace core: front end, job queue, back end.
// Depends on sfr_pkg, sfr_front, sfr_job_fifo and sfr_back.
//
// The core takes one text byte, end-of-line or end-of-buffer item per cycle and
// gives its results one per cycle on a registered output. An item is decided in
// the cycle it is accepted, then its job passes the queue and output register.
// Each item turns into at most one job in a four-entry queue, and a job yields
// up to eight replacement or flushed bytes plus a report, so the input stalls
// only while the queue is full: when the output is held back, or replacements
// longer than the needle or line flushes outrun the single output port. Plain
// text with no expansion streams at one byte per cycle. Configuration writes
// take effect at once and are meant for when the core is idle.
module stream_find_replace_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        func_i,
  input  logic [7:0]                        in_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        out_kind_o,
  output logic [7:0]                        out_byte_o,
  output logic [sfr_pkg::COUNT_W-1:0]       match_count_o,
  output logic                              last_of_run_o
);
  import sfr_pkg::*;

  logic job_push, queue_full, queue_empty, job_pop;
  job_t job_in, job_head;

  sfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .in_byte_i    (in_byte_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .queue_full_i (queue_full),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  sfr_job_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (queue_full),
    .pop_i   (job_pop),
    .empty_o (queue_empty),
    .head_o  (job_head)
  );

  sfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!queue_empty),
    .job_i         (job_head),
    .job_pop_o     (job_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .match_count_o (match_count_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
